// ----- design/wildcard_glob_matcher_macros.svh -----
// Assertion macros shared by the glob matcher modules.
// Each macro expects the enclosing module to have clock and reset ports.
`ifndef WILDCARD_GLOB_MATCHER_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define WGM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define WGM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/wgm_pkg.sv -----
// Shared types, constants and the star closure function of the glob matcher.
// No dependencies; used by every module of the block.
`default_nettype none

package wgm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int POS_N       = MAX_PATTERN + 1;

   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_ANY  = 8'h3F;
   localparam logic [7:0] CH_ESC  = 8'h5C;

   typedef enum logic [1:0] {
      ACT_BEGIN   = 2'd0,
      ACT_APPEND  = 2'd1,
      ACT_SUBJECT = 2'd2,
      ACT_END     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_LIT  = 2'd0,
      KIND_ANY  = 2'd1,
      KIND_STAR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] chr;
   } elem_type;

   // Pattern as it stands after the current item: elements, length,
   // overflow flag and the star closure of position zero.
   typedef struct packed {
      elem_type [MAX_PATTERN-1:0] elem;
      logic [LEN_W-1:0]           len;
      logic                       ovf;
      logic [POS_N-1:0]           lead;
   } pat_view_type;

   typedef struct packed {
      logic valid;
      logic matched;
      logic ovf;
   } result_type;

   // Close a position set over stars: a set bit inside a run of stars
   // carries up to the first position past the run, as a carry chain does.
   function automatic logic [POS_N-1:0] star_closure(input logic [POS_N-1:0] set,
                                                     input logic [POS_N-1:0] star);
      logic [POS_N-1:0] gen;
      logic [POS_N-1:0] sum;
      gen = set & star;
      sum = gen + star;
      return set | (sum ^ gen ^ star);
   endfunction

endpackage

`default_nettype wire

// ----- design/wgm_pattern_store.sv -----
// Pattern element registers, length, pending escape and overflow flag.
// Depends on wgm_pkg and the assertion macro header.
`default_nettype none
`include "wildcard_glob_matcher_macros.svh"

module wgm_pattern_store (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire wgm_pkg::action_type  action,
   input  wire logic [7:0]           data_byte,
   output wgm_pkg::pat_view_type     pat
);
   import wgm_pkg::*;

   elem_type [MAX_PATTERN-1:0] elem_ff, elem_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic                       esc_ff, esc_in;
   logic                       ovf_ff, ovf_in;
   logic [POS_N-1:0]           lead_ff, lead_in;
   logic                       do_store;
   elem_type                   new_elem;

   always_comb begin
      elem_in  = elem_ff;
      len_in   = len_ff;
      esc_in   = esc_ff;
      ovf_in   = ovf_ff;
      lead_in  = lead_ff;
      do_store = 1'b0;
      new_elem = '{kind: KIND_LIT, chr: data_byte};
      if (advance) begin
         case (action)
            ACT_BEGIN: begin
               len_in  = '0;
               esc_in  = 1'b0;
               ovf_in  = 1'b0;
               lead_in = POS_N'(1);
            end
            ACT_APPEND: begin
               if (esc_ff) begin
                  esc_in   = 1'b0;
                  do_store = 1'b1;
               end else if (data_byte == CH_ESC) begin
                  esc_in = 1'b1;
               end else begin
                  do_store = 1'b1;
                  if (data_byte == CH_STAR) begin
                     new_elem = '{kind: KIND_STAR, chr: 8'd0};
                  end else if (data_byte == CH_ANY) begin
                     new_elem = '{kind: KIND_ANY, chr: 8'd0};
                  end
               end
            end
            ACT_SUBJECT, ACT_END: begin
               // commit a trailing backslash as a literal
               if (esc_ff) begin
                  esc_in   = 1'b0;
                  do_store = 1'b1;
                  new_elem = '{kind: KIND_LIT, chr: CH_ESC};
               end
            end
            default: ;
         endcase
      end
      if (do_store) begin
         if (len_ff >= LEN_W'(MAX_PATTERN)) begin
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + LEN_W'(1);
            for (int i = 0; i < MAX_PATTERN; i++) begin
               if (len_ff == LEN_W'(i)) begin
                  elem_in[i] = new_elem;
                  // extend the leading run of stars
                  if (new_elem.kind == KIND_STAR && lead_ff[i]) begin
                     lead_in[i+1] = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         esc_ff  <= 1'b0;
         ovf_ff  <= 1'b0;
         lead_ff <= POS_N'(1);
      end else begin
         len_ff  <= len_in;
         esc_ff  <= esc_in;
         ovf_ff  <= ovf_in;
         lead_ff <= lead_in;
      end
   end

   assign pat.elem = elem_in;
   assign pat.len  = len_in;
   assign pat.ovf  = ovf_in;
   assign pat.lead = lead_in;

   `WGM_ASSERT_NOW(a_len_bound, 1'b1, len_ff <= LEN_W'(MAX_PATTERN), "pattern length beyond capacity")
   `WGM_ASSERT_NOW(a_lead_shape, 1'b1, lead_ff[0] && ((lead_ff & (lead_ff + POS_N'(1))) == '0), "leading closure not a contiguous run from zero")
   `WGM_ASSERT_NEXT(a_ovf_sticky, ovf_ff && !(advance && action == ACT_BEGIN), ovf_ff, "overflow cleared without begin")

endmodule

`default_nettype wire

// ----- design/wgm_match_core.sv -----
// Active position vector and one-step subject match with star closure.
// Depends on wgm_pkg and the assertion macro header.
`default_nettype none
`include "wildcard_glob_matcher_macros.svh"

module wgm_match_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire wgm_pkg::action_type  action,
   input  wire logic [7:0]           data_byte,
   input  wire wgm_pkg::pat_view_type pat,
   output wgm_pkg::result_type       res
);
   import wgm_pkg::*;

   // held closed over stars at all times
   logic [POS_N-1:0] active_ff, active_in;
   logic [POS_N-1:0] step;
   logic [POS_N-1:0] star;

   always_comb begin
      elem_type e;
      logic     live;
      step = '0;
      star = '0;
      for (int p = 0; p < MAX_PATTERN; p++) begin
         e       = pat.elem[p];
         live    = LEN_W'(p) < pat.len;
         star[p] = live && (e.kind == KIND_STAR);
         if (live && active_ff[p]) begin
            case (e.kind)
               KIND_STAR: step[p] = 1'b1;
               KIND_ANY:  step[p+1] = 1'b1;
               KIND_LIT:  step[p+1] = (e.chr == data_byte);
               default:   ;
            endcase
         end
      end
   end

   always_comb begin
      active_in   = active_ff;
      res.valid   = 1'b0;
      res.matched = !pat.ovf && active_ff[pat.len];
      res.ovf     = pat.ovf;
      if (advance) begin
         case (action)
            ACT_SUBJECT: active_in = star_closure(step, star);
            ACT_END: begin
               res.valid = 1'b1;
               active_in = pat.lead;
            end
            default: active_in = pat.lead;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= POS_N'(1);
      end else begin
         active_ff <= active_in;
      end
   end

   `WGM_ASSERT_NOW(a_match_no_ovf, res.valid && res.matched, !res.ovf, "match reported with overflow")
   `WGM_ASSERT_NEXT(a_restart, advance && action != ACT_SUBJECT, active_ff == $past(pat.lead), "active set not restarted from position zero")
   `WGM_ASSERT_NEXT(a_dead_stays, advance && action == ACT_SUBJECT && active_ff == '0, active_ff == '0, "empty active set revived by a subject byte")

endmodule

`default_nettype wire

// ----- design/wildcard_glob_matcher.sv -----
// Glob matcher with escape: pattern bytes are loaded, then a subject is
// streamed one byte per item; subject end returns matched and overflow.
//
// Request channel: req_valid/req_stall with req_action (0 begin pattern,
// 1 append pattern byte, 2 subject byte, 3 subject end) and req_data_byte.
// Response channel: rsp_valid/rsp_stall with rsp_matched and
// rsp_pattern_overflow; one response for each subject end, none otherwise.
// An item moves when valid is high and stall is low at a clock edge.
//
// Throughput is one item per cycle while no subject end waits for the
// response register. From subject end accepted to response valid, the item
// sits in the input register, then the match step loads the response
// register. The match step updates a 33-bit position vector with a single
// carry-chain add for the star closure.
// Reset clears the pattern to empty. While the response register is
// full and stalled, a subject end waits in the input register and
// req_stall rises; other items keep flowing.
`default_nettype none

module wildcard_glob_matcher (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow
);
   import wgm_pkg::*;

   logic         in_valid_ff, in_valid_in;
   action_type   in_action_ff;
   logic [7:0]   in_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         matched_ff;
   logic         ovf_ff;
   logic         advance;
   logic         req_take;
   logic         rsp_take;
   pat_view_type pat;
   result_type   res;

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   // a subject end needs a free response slot; everything else proceeds
   assign advance   = in_valid_ff &&
                      (in_action_ff != ACT_END || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= action_type'(req_action);
         in_data_ff   <= req_data_byte;
      end
      if (res.valid) begin
         matched_ff <= res.matched;
         ovf_ff     <= res.ovf;
      end
   end

   wgm_pattern_store u_store (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .action    (in_action_ff),
      .data_byte (in_data_ff),
      .pat       (pat)
   );

   wgm_match_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .action    (in_action_ff),
      .data_byte (in_data_ff),
      .pat       (pat),
      .res       (res)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_overflow = ovf_ff;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for wildcard_glob_matcher: glob patterns and subjects
// are streamed in, and each subject-end verdict is compared with a predictor.
// Depends on wgm_pkg for the action and element types and the constants.
module tb;
   import wgm_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 300;
   localparam int TARGET_ITEMS = 450;
   localparam int QUIET_TAIL   = 80;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   // Tracks the pattern and the active position set, and queues verdicts
   class match_scoreboard;
      elem_type         elems[MAX_PATTERN];
      int               pat_len;
      bit               esc_pending;
      bit               ovf;
      logic [POS_N-1:0] live;
      verdict_type      expected_verdicts[$];
      int               failures;

      function new();
         clear_pattern();
         failures = 0;
      endfunction

      function void clear_pattern();
         pat_len     = 0;
         esc_pending = 0;
         ovf         = 0;
         live        = POS_N'(1);
      endfunction

      function void store(kind_type k, logic [7:0] b);
         if (pat_len >= MAX_PATTERN) begin
            ovf = 1;
         end else begin
            elems[pat_len] = '{kind: k, chr: b};
            pat_len++;
         end
      endfunction

      function void commit_escape();
         if (esc_pending) begin
            esc_pending = 0;
            store(KIND_LIT, CH_ESC);
         end
      endfunction

      // Drop positions past the pattern, then carry set bits through stars
      function logic [POS_N-1:0] close_stars(logic [POS_N-1:0] s);
         for (int p = pat_len + 1; p < POS_N; p++)
            s[p] = 1'b0;
         for (int p = 0; p < pat_len; p++)
            if (s[p] && elems[p].kind == KIND_STAR)
               s[p+1] = 1'b1;
         return s;
      endfunction

      function void note_item(action_type act, logic [7:0] b);
         logic [POS_N-1:0] cur;
         logic [POS_N-1:0] nxt;
         verdict_type      v;
         case (act)
            ACT_BEGIN: begin
               clear_pattern();
            end
            ACT_APPEND: begin
               live = POS_N'(1);
               if (esc_pending) begin
                  esc_pending = 0;
                  store(KIND_LIT, b);
               end else if (b == CH_ESC) begin
                  esc_pending = 1;
               end else if (b == CH_STAR) begin
                  store(KIND_STAR, 8'h00);
               end else if (b == CH_ANY) begin
                  store(KIND_ANY, 8'h00);
               end else begin
                  store(KIND_LIT, b);
               end
            end
            ACT_SUBJECT: begin
               commit_escape();
               cur = close_stars(live);
               nxt = '0;
               for (int p = 0; p < pat_len; p++) begin
                  if (cur[p]) begin
                     if (elems[p].kind == KIND_STAR)
                        nxt[p] = 1'b1;
                     else if (elems[p].kind == KIND_ANY || elems[p].chr == b)
                        nxt[p+1] = 1'b1;
                  end
               end
               live = close_stars(nxt);
            end
            ACT_END: begin
               commit_escape();
               cur = close_stars(live);
               v.matched  = !ovf && cur[pat_len];
               v.overflow = ovf;
               expected_verdicts.insert(expected_verdicts.size(), v);
               live = POS_N'(1);
            end
            default: ;
         endcase
      endfunction

      function void check_verdict(logic m, logic o);
         verdict_type v;
         if (expected_verdicts.size() == 0) begin
            if (failures < 10)
               $display("unexpected verdict: matched=%0b overflow=%0b", m, o);
            failures++;
         end else begin
            v = expected_verdicts.pop_front();
            if (m !== v.matched || o !== v.overflow) begin
               if (failures < 10)
                  $display("verdict mismatch: matched exp %0b got %0b, overflow exp %0b got %0b",
                           v.matched, m, v.overflow, o);
               failures++;
            end
         end
      endfunction

      function int outstanding();
         return expected_verdicts.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = 2'd0;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;

   match_scoreboard board = new();
   int  items_sent = 0;
   int  cycles = 0;
   bit  idle_on = 1'b1;
   bit  hold_request = 1'b0;

   wildcard_glob_matcher DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_verdict(rsp_matched, rsp_pattern_overflow);
   end

   // Receiver: random stall bursts, plus one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Entered and left at a falling edge
   task automatic drive_item(input action_type act, input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid     <= 1'b0;
         req_action    <= 2'($urandom_range(0, 3));
         req_data_byte <= 8'($urandom_range(0, 255));
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= b;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      board.note_item(act, b);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(0, 4))
         0:       return "a";
         1:       return "b";
         2:       return "c";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_pattern_byte();
      case ($urandom_range(0, 9))
         0, 1:    return CH_STAR;
         2:       return CH_ANY;
         3:       return CH_ESC;
         8, 9:    return 8'($urandom_range(0, 255));
         default: return pick_letter();
      endcase
   endfunction

   // Load a pattern, then match a few subjects, most of them built to fit
   task automatic run_sequence(input int seq_no);
      logic [7:0] pat[$];
      logic [7:0] subj[$];
      int         plen;
      int         nsub;
      bit         esc;
      pat.delete();
      drive_item(ACT_BEGIN, 8'($urandom_range(0, 255)));
      if (seq_no == 0) begin
         // overflow the store: plain letters only, no escapes to shrink it
         for (int i = 0; i < MAX_PATTERN + 2; i++)
            pat.insert(pat.size(), 8'("a" + $urandom_range(0, 2)));
      end else if ($urandom_range(0, 11) == 0) begin
         plen = $urandom_range(28, 38);
         for (int i = 0; i < plen; i++)
            pat.insert(pat.size(), pick_pattern_byte());
      end else begin
         plen = $urandom_range(0, 7);
         for (int i = 0; i < plen; i++)
            pat.insert(pat.size(), pick_pattern_byte());
      end
      foreach (pat[i])
         drive_item(ACT_APPEND, pat[i]);
      nsub = $urandom_range(1, 3);
      for (int s = 0; s < nsub; s++) begin
         subj.delete();
         if ($urandom_range(0, 3) != 0) begin
            esc = 1'b0;
            foreach (pat[i]) begin
               if (esc) begin
                  esc = 1'b0;
                  subj.insert(subj.size(), pat[i]);
               end else if (pat[i] == CH_ESC) begin
                  esc = 1'b1;
               end else if (pat[i] == CH_STAR) begin
                  repeat ($urandom_range(0, 3)) subj.insert(subj.size(), pick_letter());
               end else if (pat[i] == CH_ANY) begin
                  subj.insert(subj.size(), 8'($urandom_range(0, 255)));
               end else begin
                  subj.insert(subj.size(), pat[i]);
               end
            end
            if (esc)
               subj.insert(subj.size(), CH_ESC);
            // spoil some of them
            if (subj.size() > 0 && $urandom_range(0, 4) == 0)
               subj[$urandom_range(0, subj.size() - 1)] = pick_letter();
         end else begin
            repeat ($urandom_range(0, 8)) subj.insert(subj.size(), pick_letter());
         end
         foreach (subj[i])
            drive_item(ACT_SUBJECT, subj[i]);
         drive_item(ACT_END, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int seq_no;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty pattern against empty and non-empty subjects
      drive_item(ACT_END, 8'hFF);
      drive_item(ACT_SUBJECT, 8'h00);
      drive_item(ACT_END, 8'h00);
      // Escaped star is a literal, then any-one
      drive_item(ACT_APPEND, CH_ESC);
      drive_item(ACT_APPEND, CH_STAR);
      drive_item(ACT_SUBJECT, CH_STAR);
      drive_item(ACT_END, 8'h00);
      drive_item(ACT_APPEND, CH_ANY);
      drive_item(ACT_SUBJECT, CH_STAR);
      drive_item(ACT_SUBJECT, 8'hFF);
      drive_item(ACT_END, 8'hFF);
      // Trailing backslash committed at subject end
      drive_item(ACT_APPEND, CH_ESC);
      drive_item(ACT_END, 8'h00);
      // Star, partial subject abandoned by a further append
      drive_item(ACT_BEGIN, 8'h00);
      drive_item(ACT_APPEND, CH_STAR);
      drive_item(ACT_SUBJECT, 8'hFF);
      drive_item(ACT_APPEND, 8'h00);
      drive_item(ACT_SUBJECT, "x");
      drive_item(ACT_SUBJECT, 8'h00);
      drive_item(ACT_END, 8'h00);
      // Begin drops a pending escape
      drive_item(ACT_BEGIN, 8'hFF);
      drive_item(ACT_APPEND, CH_ESC);
      drive_item(ACT_BEGIN, 8'h00);
      drive_item(ACT_END, 8'h00);

      seq_no = 0;
      while (items_sent < TARGET_ITEMS) begin
         idle_on = (items_sent < TARGET_ITEMS - QUIET_TAIL);
         if (seq_no == 3) begin
            // hold the receiver and keep offering subject ends until the block backs up
            hold_request = 1'b1;
            repeat (12) drive_item(ACT_END, 8'($urandom_range(0, 255)));
         end
         if (seq_no == 8) begin
            // stop offering, then wait for every verdict to drain
            req_valid <= 1'b0;
            @(negedge clock);
            while (board.outstanding() != 0)
               @(negedge clock);
         end
         if (seq_no > 0 && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               drive_item(action_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else begin
            run_sequence(seq_no);
         end
         seq_no++;
      end
      req_valid <= 1'b0;

      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
